@@ hdl/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray/sphere intersection package
// Shared constants and register index codes of the ray/sphere intersection
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  // Default coordinate width (signed Q16.16).
  localparam int DEF_COORD_BITS = 32;

  // Unit direction components carry this many fraction bits.
  localparam int UNIT_BITS = 30;

  // Normalized direction magnitudes have their top bit just below this bit.
  localparam int DIR_TOP = 30;

  // Width of a normalized direction magnitude.
  localparam int MAG_BITS = DIR_TOP;

  // Width of the direction norm and of a unit component magnitude.
  localparam int NORM_BITS = MAG_BITS + 1;

  // Width of the register index on the configuration port.
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_CENTER_Z      = 3'd2,
    CFG_SPHERE_RADIUS = 3'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ hdl/rsi_ray_if.sv @@
// ----------------------------------------------------------------------------
// Ray channel
// Valid/ready channel carrying one ray (origin and direction) per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsi_ray_if #(
  parameter int COORD_BITS = rsi_pkg::DEF_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic signed [COORD_BITS-1:0] origin_z;
  logic signed [COORD_BITS-1:0] dir_x;
  logic signed [COORD_BITS-1:0] dir_y;
  logic signed [COORD_BITS-1:0] dir_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    output ready
  );
endinterface

// ----------------------------------------------------------------------------
// Hit channel
// Valid/ready channel carrying one hit flag and distance per beat.
// ----------------------------------------------------------------------------
interface rsi_hit_if #(
  parameter int COORD_BITS = rsi_pkg::DEF_COORD_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [COORD_BITS-2:0] distance;

  modport source (
    output valid, hit, distance,
    input  ready
  );
  modport sink (
    input  valid, hit, distance,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/rsi_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage, with a side payload
// that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_sqrt_pipe #(
  parameter int OUT_W  = 31,
  parameter int SIDE_W = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 vld_i,
  input  wire logic [2*OUT_W-1:0]   rad_i,
  input  wire logic [SIDE_W-1:0]    side_i,
  output logic                      vld_o,
  output logic [OUT_W-1:0]          root_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int RW = 2 * OUT_W + 1;

  logic              vld_q  [OUT_W];
  logic [RW-1:0]     rem_q  [OUT_W];
  logic [OUT_W-1:0]  root_q [OUT_W];
  logic [SIDE_W-1:0] side_q [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    localparam int B = OUT_W - 1 - k;
    logic              vld_c;
    logic [RW-1:0]     rem_c;
    logic [OUT_W-1:0]  root_c;
    logic [SIDE_W-1:0] side_c;
    logic [RW-1:0]     trial;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_c  = vld_i;
      assign rem_c  = RW'(rad_i);
      assign root_c = '0;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = vld_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
      assign side_c = side_q[k-1];
    end

    // Bits of the partial root lie above B, so the two terms never overlap.
    assign trial = (RW'(root_c) << (B + 1)) + (RW'(1) << (2 * B));
    assign take  = (rem_c >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (rem_c - trial) : rem_c;
        root_q[k] <= take ? (root_c | (OUT_W'(1) << B)) : root_c;
        side_q[k] <= side_c;
      end
    end
  end

  assign vld_o  = vld_q[OUT_W-1];
  assign root_o = root_q[OUT_W-1];
  assign side_o = side_q[OUT_W-1];

endmodule

`default_nettype wire

@@ hdl/rsi_div_pipe.sv @@
// ----------------------------------------------------------------------------
// Pipelined direction divider
// Three lanes of restoring division, one quotient bit per register stage,
// that scale the normalized direction magnitudes by the inverse norm.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_div_pipe #(
  parameter int SIDE_W = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  vld_i,
  input  wire logic [2:0][rsi_pkg::MAG_BITS-1:0]     num_i,
  input  wire logic [rsi_pkg::NORM_BITS-1:0]         den_i,
  input  wire logic [SIDE_W-1:0]                     side_i,
  output logic                                       vld_o,
  output logic [2:0][rsi_pkg::NORM_BITS-1:0]         quo_o,
  output logic [SIDE_W-1:0]                          side_o
);

  import rsi_pkg::*;

  localparam int QB = NORM_BITS;
  localparam int RW = MAG_BITS + UNIT_BITS + 2;

  logic                       vld_q  [QB];
  logic [2:0][RW-1:0]         rem_q  [QB];
  logic [2:0][QB-1:0]         quo_q  [QB];
  logic [NORM_BITS-1:0]       den_q  [QB];
  logic [SIDE_W-1:0]          side_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic                 vld_c;
    logic [2:0][RW-1:0]   rem_c;
    logic [2:0][QB-1:0]   quo_c;
    logic [NORM_BITS-1:0] den_c;
    logic [SIDE_W-1:0]    side_c;
    logic [RW-1:0]        den_sh;
    logic [2:0][RW-1:0]   rem_n;
    logic [2:0][QB-1:0]   quo_n;

    if (k == 0) begin : g_first
      assign vld_c = vld_i;
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rem_c[j] = RW'(num_i[j]) << UNIT_BITS;
      end
      assign quo_c  = '0;
      assign den_c  = den_i;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = vld_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign quo_c  = quo_q[k-1];
      assign den_c  = den_q[k-1];
      assign side_c = side_q[k-1];
    end

    assign den_sh = RW'(den_c) << B;

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        if (rem_c[j] >= den_sh) begin
          rem_n[j] = rem_c[j] - den_sh;
          quo_n[j] = quo_c[j] | (QB'(1) << B);
        end else begin
          rem_n[j] = rem_c[j];
          quo_n[j] = quo_c[j];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_n;
        quo_q[k]  <= quo_n;
        den_q[k]  <= den_c;
        side_q[k] <= side_c;
      end
    end
  end

  assign vld_o  = vld_q[QB-1];
  assign quo_o  = quo_q[QB-1];
  assign side_o = side_q[QB-1];

endmodule

`default_nettype wire

@@ hdl/ray_sphere_intersect_unit.sv @@
// ----------------------------------------------------------------------------
// Ray/sphere intersection unit
// Tests one ray per beat against a configured sphere and returns the hit flag
// and the nearest strictly positive distance.
// ----------------------------------------------------------------------------
// The unit takes one ray per clock cycle while the result side keeps taking
// beats, and returns one result beat per ray, in order. The pipeline is built
// from the two bit-serial square root pipelines (31 and COORD_BITS-1 stages),
// the 31-stage direction divider, the nine short arithmetic stages around them
// and the output register. The whole pipeline advances together: when a result
// waits on the output register and the sink is not ready, every stage holds and
// ray_i.ready drops, so nothing is lost or repeated. The sphere center and
// radius are written through the plain configuration port; write them only
// while no ray is in flight, since the pipeline reads the registers directly. A
// zero direction, a ray that passes the sphere, a ray whose nearer root is zero
// or one whose roots both lie at or behind the origin reports a miss with
// distance zero; a far distance saturates to the largest value.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect_unit #(
  parameter int COORD_BITS = rsi_pkg::DEF_COORD_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [rsi_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]             cfg_wdata_i,
  rsi_ray_if.sink                                ray_i,
  rsi_hit_if.source                              hit_o
);

  import rsi_pkg::*;

  // Working widths, all derived from the coordinate width.
  localparam int C     = COORD_BITS;
  localparam int LW    = C + 1;            // origin minus center
  localparam int RADW  = C - 1;            // radius and distance
  localparam int PW    = $clog2(C);        // position of the top magnitude bit
  localparam int SHW   = 8;                // normalizing shift amount
  localparam int UW    = NORM_BITS + 1;    // signed unit component
  localparam int PRODW = UW + LW;          // unit component times offset
  localparam int DOTW  = PRODW + 2;        // sum of three products
  localparam int HW    = DOTW - UNIT_BITS; // h and cross components
  localparam int QMW   = HW - 1;           // cross component magnitude
  localparam int P2W   = 2 * QMW + 2;      // squared distance to the axis
  localparam int DISCW = 2 * RADW;         // discriminant
  localparam int NNW   = 2 * NORM_BITS;    // squared direction norm
  localparam int SIDE1 = 1 + 3 + 3 * MAG_BITS + 3 * LW;
  localparam int SIDE2 = 1 + 3 + 3 * LW;
  localparam int SIDE3 = 1 + HW;

  // Configuration registers.
  logic [C-1:0]    center_x_q, center_y_q, center_z_q;
  logic [RADW-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      radius_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X:      center_x_q <= cfg_wdata_i;
        CFG_CENTER_Y:      center_y_q <= cfg_wdata_i;
        CFG_CENTER_Z:      center_z_q <= cfg_wdata_i;
        CFG_SPHERE_RADIUS: radius_q   <= cfg_wdata_i[RADW-1:0];
        default: ;
      endcase
    end
  end

  // One enable moves every stage: the pipeline advances whenever the output
  // register is empty or its beat is taken in this cycle.
  logic out_vld_q;
  logic en;

  assign en          = !out_vld_q || hit_o.ready;
  assign ray_i.ready = en;

  // Stage A: offset from the center, direction magnitudes and their maximum.
  logic                a_vld_q;
  logic [2:0][LW-1:0]  a_l_q;
  logic [2:0][C-1:0]   a_m_q;
  logic [2:0]          a_sgn_q;
  logic [C-1:0]        a_mx_q;
  logic [2:0][LW-1:0]  a_l_d;
  logic [2:0][C-1:0]   a_m_d;
  logic [2:0]          a_sgn_d;
  logic [C-1:0]        a_mx_d;

  always_comb begin
    logic [2:0][C-1:0] dir;
    dir[0] = ray_i.dir_x;
    dir[1] = ray_i.dir_y;
    dir[2] = ray_i.dir_z;
    a_l_d[0] = LW'($signed(ray_i.origin_x)) - LW'($signed(center_x_q));
    a_l_d[1] = LW'($signed(ray_i.origin_y)) - LW'($signed(center_y_q));
    a_l_d[2] = LW'($signed(ray_i.origin_z)) - LW'($signed(center_z_q));
    a_mx_d   = '0;
    for (int i = 0; i < 3; i++) begin
      a_sgn_d[i] = dir[i][C-1];
      a_m_d[i]   = dir[i][C-1] ? (C'(0) - dir[i]) : dir[i];
      if (a_m_d[i] > a_mx_d) begin
        a_mx_d = a_m_d[i];
      end
    end
  end

  // Stage B: find the top bit of the largest magnitude.
  logic                b_vld_q;
  logic [2:0][LW-1:0]  b_l_q;
  logic [2:0][C-1:0]   b_m_q;
  logic [2:0]          b_sgn_q;
  logic [PW-1:0]       b_p_q;
  logic                b_zero_q;
  logic [PW-1:0]       b_p_d;

  always_comb begin
    b_p_d = '0;
    for (int i = 0; i < C; i++) begin
      if (a_mx_q[i]) begin
        b_p_d = PW'(i);
      end
    end
  end

  // Stage C: shift all three magnitudes so the largest tops out just below
  // the normalized range limit.
  logic                     c_vld_q;
  logic [2:0][LW-1:0]       c_l_q;
  logic [2:0][MAG_BITS-1:0] c_m_q;
  logic [2:0]               c_sgn_q;
  logic                     c_zero_q;
  logic [2:0][MAG_BITS-1:0] c_m_d;

  always_comb begin
    logic [SHW-1:0]            p_ext;
    logic [C+MAG_BITS-1:0]     ext;
    logic [C+MAG_BITS-1:0]     sh;
    p_ext = SHW'(b_p_q);
    for (int i = 0; i < 3; i++) begin
      ext = (C + MAG_BITS)'(b_m_q[i]);
      if (p_ext >= SHW'(DIR_TOP - 1)) begin
        sh = ext >> (p_ext - SHW'(DIR_TOP - 1));
      end else begin
        sh = ext << (SHW'(DIR_TOP - 1) - p_ext);
      end
      c_m_d[i] = sh[MAG_BITS-1:0];
    end
  end

  // Stage D: squares of the normalized magnitudes.
  logic                       d_vld_q;
  logic [2:0][LW-1:0]         d_l_q;
  logic [2:0][MAG_BITS-1:0]   d_m_q;
  logic [2:0]                 d_sgn_q;
  logic                       d_zero_q;
  logic [2:0][2*MAG_BITS-1:0] d_sq_q;

  // Stage E: squared norm.
  logic                     e_vld_q;
  logic [2:0][LW-1:0]       e_l_q;
  logic [2:0][MAG_BITS-1:0] e_m_q;
  logic [2:0]               e_sgn_q;
  logic                     e_zero_q;
  logic [NNW-1:0]           e_nn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= ray_i.valid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_l_q    <= a_l_d;
      a_m_q    <= a_m_d;
      a_sgn_q  <= a_sgn_d;
      a_mx_q   <= a_mx_d;

      b_l_q    <= a_l_q;
      b_m_q    <= a_m_q;
      b_sgn_q  <= a_sgn_q;
      b_p_q    <= b_p_d;
      b_zero_q <= (a_mx_q == '0);

      c_l_q    <= b_l_q;
      c_m_q    <= c_m_d;
      c_sgn_q  <= b_sgn_q;
      c_zero_q <= b_zero_q;

      d_l_q    <= c_l_q;
      d_m_q    <= c_m_q;
      d_sgn_q  <= c_sgn_q;
      d_zero_q <= c_zero_q;
      for (int i = 0; i < 3; i++) begin
        d_sq_q[i] <= (2 * MAG_BITS)'(c_m_q[i]) * (2 * MAG_BITS)'(c_m_q[i]);
      end

      e_l_q    <= d_l_q;
      e_m_q    <= d_m_q;
      e_sgn_q  <= d_sgn_q;
      e_zero_q <= d_zero_q;
      e_nn_q   <= NNW'(d_sq_q[0]) + NNW'(d_sq_q[1]) + NNW'(d_sq_q[2]);
    end
  end

  // Direction norm: floor square root of the squared norm.
  logic                     n_vld;
  logic [NORM_BITS-1:0]     n_root;
  logic [SIDE1-1:0]         n_side;
  logic                     n_zero;
  logic [2:0]               n_sgn;
  logic [2:0][MAG_BITS-1:0] n_m;
  logic [2:0][LW-1:0]       n_l;

  rsi_sqrt_pipe #(
    .OUT_W  (NORM_BITS),
    .SIDE_W (SIDE1)
  ) u_norm_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (e_vld_q),
    .rad_i  (e_nn_q),
    .side_i ({e_zero_q, e_sgn_q, e_m_q, e_l_q}),
    .vld_o  (n_vld),
    .root_o (n_root),
    .side_o (n_side)
  );

  assign {n_zero, n_sgn, n_m, n_l} = n_side;

  // Unit direction magnitudes.
  logic                      u_vld;
  logic [2:0][NORM_BITS-1:0] u_mag;
  logic [SIDE2-1:0]          u_side;
  logic                      u_zero;
  logic [2:0]                u_sgn;
  logic [2:0][LW-1:0]        u_l;

  rsi_div_pipe #(
    .SIDE_W (SIDE2)
  ) u_dir_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (n_vld),
    .num_i  (n_m),
    .den_i  (n_root),
    .side_i ({n_zero, n_sgn, n_l}),
    .vld_o  (u_vld),
    .quo_o  (u_mag),
    .side_o (u_side)
  );

  assign {u_zero, u_sgn, u_l} = u_side;

  // Stage F: the nine products of unit direction and offset.
  // Order: ux*lx, uy*ly, uz*lz, uy*lz, uz*ly, uz*lx, ux*lz, ux*ly, uy*lx.
  logic                    f_vld_q;
  logic                    f_zero_q;
  logic signed [PRODW-1:0] f_p_q [9];
  logic signed [UW-1:0]    us [3];
  logic signed [LW-1:0]    ls [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      us[i] = u_sgn[i] ? -$signed(UW'(u_mag[i])) : $signed(UW'(u_mag[i]));
      ls[i] = $signed(u_l[i]);
    end
  end

  // Stage G: h = -(u . L) and the cross product u x L, both floored by the
  // unit scale. Their width HW leaves room for either value, so no clamp is
  // needed.
  logic                 g_vld_q;
  logic                 g_zero_q;
  logic signed [HW-1:0] g_h_q;
  logic signed [HW-1:0] g_q_q [3];
  logic signed [DOTW-1:0] dot_neg;
  logic signed [DOTW-1:0] crs [3];

  assign dot_neg = -(DOTW'(f_p_q[0]) + DOTW'(f_p_q[1]) + DOTW'(f_p_q[2]));
  assign crs[0]  = DOTW'(f_p_q[3]) - DOTW'(f_p_q[4]);
  assign crs[1]  = DOTW'(f_p_q[5]) - DOTW'(f_p_q[6]);
  assign crs[2]  = DOTW'(f_p_q[7]) - DOTW'(f_p_q[8]);

  // Stage H: squares of the cross components and of the radius.
  logic                 h_vld_q;
  logic                 h_zero_q;
  logic signed [HW-1:0] h_h_q;
  logic [2*QMW-1:0]     h_sq_q [3];
  logic [DISCW-1:0]     h_rr_q;
  logic [QMW-1:0]       qm [3];

  always_comb begin
    logic [HW-1:0] qa;
    for (int i = 0; i < 3; i++) begin
      qa    = g_q_q[i][HW-1] ? (HW'(0) - HW'(g_q_q[i])) : HW'(g_q_q[i]);
      qm[i] = qa[QMW-1:0];
    end
  end

  // Stage I: squared distance from the center to the ray line, compared with
  // the squared radius.
  logic                 i_vld_q;
  logic                 i_miss_q;
  logic signed [HW-1:0] i_h_q;
  logic [DISCW-1:0]     i_disc_q;
  logic [P2W-1:0]       p2;

  assign p2 = P2W'(h_sq_q[0]) + P2W'(h_sq_q[1]) + P2W'(h_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= u_vld;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_zero_q <= u_zero;
      f_p_q[0] <= PRODW'(us[0]) * PRODW'(ls[0]);
      f_p_q[1] <= PRODW'(us[1]) * PRODW'(ls[1]);
      f_p_q[2] <= PRODW'(us[2]) * PRODW'(ls[2]);
      f_p_q[3] <= PRODW'(us[1]) * PRODW'(ls[2]);
      f_p_q[4] <= PRODW'(us[2]) * PRODW'(ls[1]);
      f_p_q[5] <= PRODW'(us[2]) * PRODW'(ls[0]);
      f_p_q[6] <= PRODW'(us[0]) * PRODW'(ls[2]);
      f_p_q[7] <= PRODW'(us[0]) * PRODW'(ls[1]);
      f_p_q[8] <= PRODW'(us[1]) * PRODW'(ls[0]);

      g_zero_q <= f_zero_q;
      g_h_q    <= HW'(dot_neg >>> UNIT_BITS);
      for (int i = 0; i < 3; i++) begin
        g_q_q[i] <= HW'(crs[i] >>> UNIT_BITS);
      end

      h_zero_q <= g_zero_q;
      h_h_q    <= g_h_q;
      for (int i = 0; i < 3; i++) begin
        h_sq_q[i] <= (2 * QMW)'(qm[i]) * (2 * QMW)'(qm[i]);
      end
      h_rr_q   <= DISCW'(radius_q) * DISCW'(radius_q);

      i_h_q    <= h_h_q;
      i_miss_q <= h_zero_q || (p2 > P2W'(h_rr_q));
      i_disc_q <= h_rr_q - p2[DISCW-1:0];
    end
  end

  // Half chord length: floor square root of the discriminant.
  logic                 s_vld;
  logic [RADW-1:0]      s_root;
  logic [SIDE3-1:0]     s_side;
  logic                 s_miss;
  logic [HW-1:0]        s_h;

  rsi_sqrt_pipe #(
    .OUT_W  (RADW),
    .SIDE_W (SIDE3)
  ) u_disc_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (i_vld_q),
    .rad_i  (i_disc_q),
    .side_i ({i_miss_q, i_h_q}),
    .vld_o  (s_vld),
    .root_o (s_root),
    .side_o (s_side)
  );

  assign {s_miss, s_h} = s_side;

  // Output stage: pick the nearest strictly positive root and saturate it.
  localparam logic [HW:0] DistMax = (HW + 1)'({RADW{1'b1}});

  logic                 hit_d;
  logic [RADW-1:0]      dist_d;
  logic                 hit_q;
  logic [RADW-1:0]      dist_q;

  always_comb begin
    logic signed [HW:0] nr;
    logic signed [HW:0] fr;
    logic signed [HW:0] t;
    nr = $signed((HW + 1)'($signed(s_h))) - $signed((HW + 1)'(s_root));
    fr = $signed((HW + 1)'($signed(s_h))) + $signed((HW + 1)'(s_root));
    t  = (nr > 0) ? nr : fr;
    hit_d  = !s_miss && (fr > 0) && (nr != 0);
    dist_d = '0;
    if (hit_d) begin
      dist_d = ($unsigned(t) > DistMax) ? {RADW{1'b1}} : t[RADW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  assign hit_o.valid    = out_vld_q;
  assign hit_o.hit      = hit_q;
  assign hit_o.distance = dist_q;

endmodule

`default_nettype wire

@@ hdl/rsi_checker.sv @@
// ----------------------------------------------------------------------------
// Ray/sphere intersection checker
// Port-level assertions on the intersection unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_checker #(
  parameter int COORD_BITS = rsi_pkg::DEF_COORD_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_ready_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire logic                  hit_i,
  input  wire logic [COORD_BITS-2:0] distance_i
);

  // A miss always reports a zero distance.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i |-> distance_i == '0)
    else $error("miss beat with nonzero distance");

  // A hit is at a strictly positive distance.
  a_hit_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> distance_i != '0)
    else $error("hit beat with zero distance");

  // An empty output register never holds back the ray side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("ray side stalled with empty output");

  // A stalled result freezes the pipeline, so no ray enters.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("ray accepted while result stalled");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(hit_i) && $stable(distance_i))
    else $error("result beat changed while stalled");

endmodule

bind ray_sphere_intersect_unit rsi_checker #(
  .COORD_BITS (COORD_BITS)
) u_rsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (ray_i.ready),
  .out_valid_i (hit_o.valid),
  .out_ready_i (hit_o.ready),
  .hit_i       (hit_o.hit),
  .distance_i  (hit_o.distance)
);

`default_nettype wire
